// ----- sv/uv_sphere_index_generator_assert.svh -----
// Assertion macros for the UV sphere index generator.
// Included by the top level; no other dependencies.
`ifndef UV_SPHERE_INDEX_GENERATOR_ASSERT_SVH
`define UV_SPHERE_INDEX_GENERATOR_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication under reset.
`define UVSIG_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("uvsig assertion failed");
// Next-cycle implication under reset.
`define UVSIG_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("uvsig assertion failed");
`else
`define UVSIG_ASSERT_IMP(label, clk, rst_n, pre, post)
`define UVSIG_ASSERT_NXT(label, clk, rst_n, pre, post)
`endif

`endif

// ----- sv/uvsig_pkg.sv -----
// Types and constants shared by the UV sphere index generator.
// No dependencies.
package uvsig_pkg;

    localparam int IDX_W   = 15;
    localparam int PT_W    = 8;
    localparam int RING_W  = 7;
    localparam int CNT_W   = 9;   // holds 2 * refinement up to 256
    localparam int REF_W   = 8;

    typedef enum logic [3:0] {
        PH_TOP    = 4'b0001,
        PH_BANDS  = 4'b0010,
        PH_BOTTOM = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

    typedef struct packed {
        phase_t             phase;
        logic [RING_W-1:0]  ring_count;
        logic [PT_W-1:0]    point_count;
        logic               quad_half;
        logic [IDX_W-1:0]   ring_base;
    } gen_state_t;

    // Effective ring geometry derived from the refinement register.
    typedef struct packed {
        logic [CNT_W-1:0]   ring_points;   // P = 2r
        logic [RING_W-1:0]  band_limit;    // r - 1
    } geom_t;

    typedef struct packed {
        logic [IDX_W-1:0]   index_a;
        logic [IDX_W-1:0]   index_b;
        logic [IDX_W-1:0]   index_c;
        logic               last_triangle;
    } tri_t;

endpackage

// ----- sv/uv_sphere_index_generator.sv -----
// Top level of the UV sphere index generator: config register, counter
// state, output register. Depends on uvsig_pkg, uvsig_step and the assert header.
//
//  channel   signals                                       direction
//  config    refinement_wr_en, refinement_wr_data          in
//  request   in_valid, in_ready, restart                   in (in_ready out)
//  triangle  out_valid, out_ready, index_a/b/c, last_triangle  out (out_ready in)
//
// One request beat is taken per cycle while in_ready is high; its triangle
// sits in the output register in the cycle after. The counter update and index
// adds are one combinational pass, so the rate is one triangle per clock while the output is not stalled.
// A request is taken whenever the output register is empty or being drained.
// After reset the generator is in its done phase until a restart beat.
`include "uv_sphere_index_generator_assert.svh"

module uv_sphere_index_generator
    import uvsig_pkg::*;
#(
    parameter int MAX_REFINEMENT = 128
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             refinement_wr_en,
    input  logic [REF_W-1:0] refinement_wr_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             restart,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [IDX_W-1:0] index_a,
    output logic [IDX_W-1:0] index_b,
    output logic [IDX_W-1:0] index_c,
    output logic             last_triangle
);

    localparam logic [REF_W-1:0] MAX_R = REF_W'(MAX_REFINEMENT);
    localparam logic [REF_W-1:0] MIN_R = REF_W'(3);

    logic [REF_W-1:0] refinement_reg;
    logic [REF_W-1:0] ref_eff;
    geom_t            geom;
    gen_state_t       state_reg;
    gen_state_t       state_next;
    tri_t             step_tri;
    logic             step_emit;
    tri_t             out_tri_reg;
    logic             out_valid_reg;
    logic             in_accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            refinement_reg <= MIN_R;
        end
        else if (refinement_wr_en)
        begin
            refinement_reg <= refinement_wr_data;
        end
    end

    always_comb
    begin
        if (refinement_reg < MIN_R)
        begin
            ref_eff = MIN_R;
        end
        else if (refinement_reg > MAX_R)
        begin
            ref_eff = MAX_R;
        end
        else
        begin
            ref_eff = refinement_reg;
        end
    end

    assign geom.ring_points = {ref_eff, 1'b0};
    assign geom.band_limit  = RING_W'(ref_eff - REF_W'(1));

    uvsig_step u_step (
        .state      (state_reg),
        .restart    (restart),
        .geom       (geom),
        .state_next (state_next),
        .tri_out    (step_tri),
        .emit       (step_emit)
    );

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase       <= PH_DONE;
            state_reg.ring_count  <= '0;
            state_reg.point_count <= '0;
            state_reg.quad_half   <= 1'b0;
            state_reg.ring_base   <= '0;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                state_reg <= state_next;
            end
            if (in_accept && step_emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && step_emit)
        begin
            out_tri_reg <= step_tri;
        end
    end

    assign out_valid     = out_valid_reg;
    assign index_a       = out_tri_reg.index_a;
    assign index_b       = out_tri_reg.index_b;
    assign index_c       = out_tri_reg.index_c;
    assign last_triangle = out_tri_reg.last_triangle;

    // A request that yields a triangle always fills the output register.
    `UVSIG_ASSERT_NXT(a_emit_fills, clk, rst_n, in_accept && step_emit, out_valid_reg)
    // The flagged bottom cap triangle leaves the generator in its done phase.
    `UVSIG_ASSERT_NXT(a_last_done, clk, rst_n, in_accept && step_emit && step_tri.last_triangle, state_reg.phase == PH_DONE)
    // Top cap triangles always fan from the top pole.
    `UVSIG_ASSERT_NXT(a_top_pole, clk, rst_n, in_accept && (restart || state_reg.phase == PH_TOP), index_b == '0)

endmodule

// ----- sv/uvsig_step.sv -----
// Next-triangle logic: computes one triangle (none in the done phase) and the next counter state.
// Depends on uvsig_pkg.
module uvsig_step
    import uvsig_pkg::*;
(
    input  gen_state_t state,
    input  logic       restart,
    input  geom_t      geom,
    output gen_state_t state_next,
    output tri_t       tri_out,
    output logic       emit
);

    gen_state_t       cur;
    logic [CNT_W-1:0] inc;
    logic             wrap;
    logic [IDX_W-1:0] i15;
    logic [IDX_W-1:0] nx15;
    logic [IDX_W-1:0] p15;
    logic [IDX_W-1:0] b;
    logic [RING_W-1:0] ring_inc;

    always_comb
    begin
        if (restart)
        begin
            cur.phase       = PH_TOP;
            cur.ring_count  = '0;
            cur.point_count = '0;
            cur.quad_half   = 1'b0;
            cur.ring_base   = '0;
        end
        else
        begin
            cur = state;
        end
    end

    assign inc      = {1'b0, cur.point_count} + CNT_W'(1);
    assign wrap     = (inc >= geom.ring_points);
    assign i15      = IDX_W'(cur.point_count);
    assign nx15     = wrap ? '0 : IDX_W'(inc);
    assign p15      = IDX_W'(geom.ring_points);
    assign b        = cur.ring_base;
    assign ring_inc = cur.ring_count + RING_W'(1);

    always_comb
    begin
        state_next = cur;
        tri_out    = '0;
        emit       = 1'b0;
        case (cur.phase)
            PH_TOP:
            begin
                emit            = 1'b1;
                tri_out.index_a = IDX_W'(1) + nx15;
                tri_out.index_b = '0;
                tri_out.index_c = IDX_W'(1) + i15;
                if (wrap)
                begin
                    state_next.point_count = '0;
                    state_next.phase       = PH_BANDS;
                    state_next.ring_count  = RING_W'(1);
                    state_next.quad_half   = 1'b0;
                    state_next.ring_base   = IDX_W'(1) + p15;
                end
                else
                begin
                    state_next.point_count = inc[PT_W-1:0];
                end
            end
            PH_BANDS:
            begin
                emit            = 1'b1;
                tri_out.index_a = b + nx15;
                if (!cur.quad_half)
                begin
                    tri_out.index_b      = b + i15 - p15;
                    tri_out.index_c      = b + i15;
                    state_next.quad_half = 1'b1;
                end
                else
                begin
                    tri_out.index_b      = b + nx15 - p15;
                    tri_out.index_c      = b + i15 - p15;
                    state_next.quad_half = 1'b0;
                    if (wrap)
                    begin
                        state_next.point_count = '0;
                        state_next.ring_count  = ring_inc;
                        // The last band also ends if the ring counter wrapped.
                        if (ring_inc >= geom.band_limit || ring_inc == '0)
                        begin
                            state_next.phase = PH_BOTTOM;
                        end
                        else
                        begin
                            state_next.ring_base = b + p15;
                        end
                    end
                    else
                    begin
                        state_next.point_count = inc[PT_W-1:0];
                    end
                end
            end
            PH_BOTTOM:
            begin
                emit                  = 1'b1;
                tri_out.index_a       = b + p15;
                tri_out.index_b       = b + nx15;
                tri_out.index_c       = b + i15;
                tri_out.last_triangle = wrap;
                if (wrap)
                begin
                    state_next.phase       = PH_DONE;
                    state_next.point_count = '0;
                end
                else
                begin
                    state_next.point_count = inc[PT_W-1:0];
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

endmodule
